FILE: hdl/binary_min_heap_queue_defines.svh
// Assertion macros for the binary min-heap queue.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BMHQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bmhq_pkg.sv
// Shared types and codes for the binary min-heap queue.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package bmhq_pkg;

  // Default number of heap entries.
  localparam int DEPTH_DEF = 256;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes returned with every result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // One stored heap entry.
  typedef struct packed {
    logic signed [31:0] prio;
    logic [31:0]        data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input command.
  typedef struct packed {
    logic               op;
    logic signed [31:0] priority_req;
    logic [31:0]        payload;
  } in_t;

  // Result of one command.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_priority;
    logic [31:0]        out_payload;
    logic [8:0]         count;
    logic               is_empty;
  } res_t;

endpackage

FILE: hdl/bmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the heap array for the queue.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue kept in one synchronous RAM, one command at a time.
// Insert sifts the new entry up, comparing it with one parent at a time until it stops or reaches the root;
// remove reads the root and the last entry, then sifts down, reading the left and, if present, right child.
// A 1-cycle result strobe follows each command.
// A refused command goes straight to the strobe; busy drops after the strobe and the receiver cannot stall.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue #(
  parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bmhq_pkg::in_t  in_data,
  output logic           out_valid,
  output bmhq_pkg::res_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CHK   = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_RD_ROOT  = 4'd3;
  localparam logic [3:0] S_RD_LAST  = 4'd4;
  localparam logic [3:0] S_DN_START = 4'd5;
  localparam logic [3:0] S_DN_CHK   = 4'd6;
  localparam logic [3:0] S_DN_LEFT  = 4'd7;
  localparam logic [3:0] S_DN_RIGHT = 4'd8;
  localparam logic [3:0] S_DN_CMP   = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    pick_r, pick_nxt;
  bmhq_pkg::entry_t entry_r, entry_nxt;
  bmhq_pkg::entry_t child_r, child_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      rm_prio_r, rm_prio_nxt;
  logic [31:0]      rm_data_r, rm_data_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  bmhq_pkg::entry_t            ram_wentry;
  logic [AW-1:0]               ram_raddr;
  logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata;
  bmhq_pkg::entry_t            rd_entry;

  logic [IW-1:0] left_idx;
  logic [IW-1:0] right_idx;
  logic [IW-1:0] cnt_ext;
  logic [AW-1:0] parent_idx;

  // Heap array storage.
  bmhq_ram #(
    .WIDTH (bmhq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wentry),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_entry = bmhq_pkg::entry_t'(ram_rdata);

  // Tree index arithmetic around the current hole position.
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign cnt_ext    = IW'(count_r);
  assign parent_idx = (pos_r - AW'(1)) >> 1;

  // Sequencer: the moving entry stays in entry_r while the hole walks the tree.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    pick_nxt    = pick_r;
    entry_nxt   = entry_r;
    child_nxt   = child_r;
    status_nxt  = status_r;
    rm_prio_nxt = rm_prio_r;
    rm_data_nxt = rm_data_r;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wentry  = entry_r;
    ram_raddr   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = bmhq_pkg::STATUS_OK;
          rm_prio_nxt = '0;
          rm_data_nxt = '0;
          entry_nxt.prio = in_data.priority_req;
          entry_nxt.data = in_data.payload;
          if (in_data.op == bmhq_pkg::OP_INSERT) begin
            if (count_r >= CW'(DEPTH)) begin
              status_nxt = bmhq_pkg::STATUS_FULL;
              state_nxt  = S_RESP;
            end else begin
              pos_nxt   = count_r[AW-1:0];
              state_nxt = S_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bmhq_pkg::STATUS_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_RD_ROOT;
            end
          end
        end
      end

      // Sift up: fetch the parent unless the hole reached the root.
      S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          ram_raddr = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end

      // Move the parent down if the new entry is strictly smaller.
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (entry_r.prio < rd_entry.prio) begin
          ram_wentry = rd_entry;
          pos_nxt    = parent_idx;
          state_nxt  = S_UP_CHK;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RD_ROOT: begin
        ram_raddr = '0;
        state_nxt = S_RD_LAST;
      end

      // Root arrives; fetch the last entry and shrink the count.
      S_RD_LAST: begin
        rm_prio_nxt = rd_entry.prio;
        rm_data_nxt = rd_entry.data;
        ram_raddr   = AW'(count_r - CW'(1));
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_DN_START;
      end

      S_DN_START: begin
        entry_nxt = rd_entry;
        pos_nxt   = '0;
        state_nxt = S_DN_CHK;
      end

      // Sift down: stop when the hole has no left child.
      S_DN_CHK: begin
        if (left_idx >= cnt_ext) begin
          ram_we    = (count_r != '0);
          state_nxt = S_RESP;
        end else begin
          ram_raddr = left_idx[AW-1:0];
          state_nxt = S_DN_LEFT;
        end
      end

      S_DN_LEFT: begin
        child_nxt = rd_entry;
        pick_nxt  = left_idx[AW-1:0];
        if (right_idx < cnt_ext) begin
          ram_raddr = right_idx[AW-1:0];
          state_nxt = S_DN_RIGHT;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      // The right child wins only when strictly smaller.
      S_DN_RIGHT: begin
        if (rd_entry.prio < child_r.prio) begin
          child_nxt = rd_entry;
          pick_nxt  = right_idx[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (child_r.prio < entry_r.prio) begin
          ram_wentry = child_r;
          pos_nxt    = pick_r;
          state_nxt  = S_DN_CHK;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    pick_r    <= pick_nxt;
    entry_r   <= entry_nxt;
    child_r   <= child_nxt;
    status_r  <= status_nxt;
    rm_prio_r <= rm_prio_nxt;
    rm_data_r <= rm_data_nxt;
  end

  // Result transfer, one cycle wide.
  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_RESP);
  assign out_data.status       = status_r;
  assign out_data.out_priority = rm_prio_r;
  assign out_data.out_payload  = rm_data_r;
  assign out_data.count        = 9'(count_r);
  assign out_data.is_empty     = (count_r == '0);

  // Checks.
  `BMHQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `BMHQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted command not busy")
  `BMHQ_ASSERT_NEXT(a_strobe_once, clk, rst_n, out_valid, !out_valid && !busy, "strobe too long")
  `BMHQ_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (status_r == bmhq_pkg::STATUS_FULL), count_r == CW'(DEPTH), "full refusal below depth")

endmodule
